/* rtl/plane_coordinate_mapper_core_assert.svh */
// Assertion macros for the plane coordinate mapper.
// Expects aclk and aresetn in the scope of each use.
`ifndef PLANE_COORDINATE_MAPPER_CORE_ASSERT_SVH
`define PLANE_COORDINATE_MAPPER_CORE_ASSERT_SVH

// same-cycle implication
`define PCM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/pcm_pkg.sv */
// Types, constants and plane permutation tables for the plane coordinate mapper.
// No dependencies.
package pcm_pkg;

    localparam int CoordW = 32;
    localparam int EntryW = 16;
    localparam int CoefW  = EntryW + 1;
    localparam int ProdW  = CoefW + CoordW;
    localparam int SumW   = ProdW + 2;
    localparam int FracShift = 14;
    localparam int RowW   = 3 * EntryW;

    typedef logic signed [CoordW-1:0] coord_t;
    typedef logic signed [EntryW-1:0] entry_t;
    typedef logic signed [CoefW-1:0]  coef_t;
    typedef logic signed [ProdW-1:0]  prod_t;
    typedef logic signed [SumW-1:0]   sum_t;
    typedef logic [RowW-1:0]          row_t;
    typedef logic [1:0]               plane_t;
    typedef logic [1:0]               idx_t;

    localparam plane_t PLANE_AXIAL    = 2'd0;
    localparam plane_t PLANE_SAGITTAL = 2'd1;
    localparam plane_t PLANE_CORONAL  = 2'd2;
    localparam plane_t PLANE_NONE     = 2'd3;

    localparam idx_t CFG_ORIENT_ROW0 = 2'd0;
    localparam idx_t CFG_ORIENT_ROW1 = 2'd1;
    localparam idx_t CFG_ORIENT_ROW2 = 2'd2;

    localparam row_t ORIENT_ROW0_RST = 48'h0000_0000_4000;
    localparam row_t ORIENT_ROW1_RST = 48'h0000_4000_0000;
    localparam row_t ORIENT_ROW2_RST = 48'h4000_0000_0000;

    localparam coord_t COORD_MAX = coord_t'(32'h7FFF_FFFF);
    localparam coord_t COORD_MIN = coord_t'(32'h8000_0000);
    localparam sum_t   SUM_MAX   = sum_t'(COORD_MAX);
    localparam sum_t   SUM_MIN   = sum_t'(COORD_MIN);

    // source row of O for output row k of the combined matrix
    function automatic idx_t plane_src(input plane_t plane, input idx_t k);
        idx_t r;
        r = k;
        unique case (plane)
            PLANE_SAGITTAL: begin
                unique case (k)
                    2'd0:    r = 2'd1;
                    2'd1:    r = 2'd2;
                    default: r = 2'd0;
                endcase
            end
            PLANE_CORONAL: begin
                unique case (k)
                    2'd0:    r = 2'd0;
                    2'd1:    r = 2'd2;
                    default: r = 2'd1;
                endcase
            end
            default: r = k;
        endcase
        return r;
    endfunction

    // sign of output row k: 1 negates
    function automatic logic plane_neg(input plane_t plane, input idx_t k);
        logic n;
        n = 1'b0;
        unique case (plane)
            PLANE_SAGITTAL: n = (k == 2'd1);
            PLANE_CORONAL:  n = (k == 2'd0) || (k == 2'd1);
            default:        n = (k == 2'd0);
        endcase
        return n;
    endfunction

endpackage

/* rtl/plane_coordinate_mapper_core.sv */
// Plane coordinate mapper top level: 3x3 signed-permuted orientation transform.
// Depends on pcm_pkg and plane_coordinate_mapper_core_assert.svh.
//
// Maps one signed Q16.16 point per beat through M = P*O (or its transpose when
// s_inverse is set), where O is the orientation matrix held in three 48-bit
// row registers (Q2.14 entries, column 0 in the low bits) and P is the fixed
// signed permutation of the axial, sagittal or coronal plane (plane code 3
// acts as axial). Each sum is floored by 2^14 and saturated to 32 bits, then
// optionally made absolute. The datapath is three register stages (selected
// coefficients, nine 17x32 products, sum and saturate), and one beat is taken
// every cycle while the output side keeps up. Write the orientation rows only
// while the block is empty; index 3 is ignored.
module plane_coordinate_mapper_core (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  pcm_pkg::idx_t          cfg_index,
    input  pcm_pkg::row_t          cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic signed [31:0]     s_coord_x,
    input  logic signed [31:0]     s_coord_y,
    input  logic signed [31:0]     s_coord_z,
    input  logic [1:0]             s_plane,
    input  logic                   s_inverse,
    input  logic                   s_take_absolute,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic signed [31:0]     m_out_x,
    output logic signed [31:0]     m_out_y,
    output logic signed [31:0]     m_out_z
);

    `include "plane_coordinate_mapper_core_assert.svh"

    pcm_pkg::row_t   orient_reg [3];

    logic            st1_valid_reg;
    logic            st1_abs_reg;
    pcm_pkg::coef_t  st1_coef_reg  [3][3];
    pcm_pkg::coord_t st1_coord_reg [3];

    logic            st2_valid_reg;
    logic            st2_abs_reg;
    pcm_pkg::prod_t  st2_prod_reg  [3][3];

    logic            st3_valid_reg;
    logic            st3_abs_reg;
    pcm_pkg::coord_t st3_res_reg   [3];

    pcm_pkg::coef_t  coef_next     [3][3];
    pcm_pkg::prod_t  prod_next     [3][3];
    pcm_pkg::coord_t res_next      [3];
    pcm_pkg::sum_t   acc           [3];
    pcm_pkg::sum_t   acc_q         [3];
    pcm_pkg::coord_t sat_val       [3];

    logic rdy1, rdy2, rdy3;

    // stage enables
    assign rdy3    = !st3_valid_reg || m_ready;
    assign rdy2    = !st2_valid_reg || rdy3;
    assign rdy1    = !st1_valid_reg || rdy2;
    assign s_ready = rdy1;

    // orientation rows
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_reg[0] <= pcm_pkg::ORIENT_ROW0_RST;
            orient_reg[1] <= pcm_pkg::ORIENT_ROW1_RST;
            orient_reg[2] <= pcm_pkg::ORIENT_ROW2_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pcm_pkg::CFG_ORIENT_ROW0: orient_reg[0] <= cfg_wdata;
                pcm_pkg::CFG_ORIENT_ROW1: orient_reg[1] <= cfg_wdata;
                pcm_pkg::CFG_ORIENT_ROW2: orient_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // coefficient selection: term j of output i is M[i][j], or M[j][i] when inverse
    always_comb begin
        pcm_pkg::idx_t   k;
        pcm_pkg::idx_t   col;
        pcm_pkg::idx_t   src;
        pcm_pkg::row_t   row;
        pcm_pkg::entry_t e;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                k   = s_inverse ? 2'(j) : 2'(i);
                col = s_inverse ? 2'(i) : 2'(j);
                src = pcm_pkg::plane_src(s_plane, k);
                unique case (src)
                    2'd0:    row = orient_reg[0];
                    2'd1:    row = orient_reg[1];
                    default: row = orient_reg[2];
                endcase
                e = pcm_pkg::entry_t'(row[16*col +: 16]);
                coef_next[i][j] = pcm_pkg::plane_neg(s_plane, k) ?
                                  -pcm_pkg::coef_t'(e) : pcm_pkg::coef_t'(e);
            end
        end
    end

    // products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                prod_next[i][j] = pcm_pkg::prod_t'(st1_coef_reg[i][j])
                                * pcm_pkg::prod_t'(st1_coord_reg[j]);
            end
        end
    end

    // sum, floor shift, saturate, optional absolute
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i]   = pcm_pkg::sum_t'(st2_prod_reg[i][0])
                     + pcm_pkg::sum_t'(st2_prod_reg[i][1])
                     + pcm_pkg::sum_t'(st2_prod_reg[i][2]);
            acc_q[i] = acc[i] >>> pcm_pkg::FracShift;
            if (acc_q[i] > pcm_pkg::SUM_MAX) begin
                sat_val[i] = pcm_pkg::COORD_MAX;
            end else if (acc_q[i] < pcm_pkg::SUM_MIN) begin
                sat_val[i] = pcm_pkg::COORD_MIN;
            end else begin
                sat_val[i] = pcm_pkg::coord_t'(acc_q[i][31:0]);
            end
            if (st2_abs_reg && sat_val[i][31]) begin
                res_next[i] = (sat_val[i] == pcm_pkg::COORD_MIN) ?
                              pcm_pkg::COORD_MAX : -sat_val[i];
            end else begin
                res_next[i] = sat_val[i];
            end
        end
    end

    // pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            st2_valid_reg <= 1'b0;
            st3_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                st1_valid_reg <= s_valid;
            end
            if (rdy2) begin
                st2_valid_reg <= st1_valid_reg;
            end
            if (rdy3) begin
                st3_valid_reg <= st2_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        if (rdy1 && s_valid) begin
            st1_coef_reg     <= coef_next;
            st1_coord_reg[0] <= s_coord_x;
            st1_coord_reg[1] <= s_coord_y;
            st1_coord_reg[2] <= s_coord_z;
            st1_abs_reg      <= s_take_absolute;
        end
        if (rdy2 && st1_valid_reg) begin
            st2_prod_reg <= prod_next;
            st2_abs_reg  <= st1_abs_reg;
        end
        if (rdy3 && st2_valid_reg) begin
            st3_res_reg <= res_next;
            st3_abs_reg <= st2_abs_reg;
        end
    end

    assign m_valid = st3_valid_reg;
    assign m_out_x = st3_res_reg[0];
    assign m_out_y = st3_res_reg[1];
    assign m_out_z = st3_res_reg[2];

    `PCM_ASSERT_NOW(a_no_bubble_stall, !s_ready,
        st1_valid_reg && st2_valid_reg && st3_valid_reg,
        "input stalled while a pipeline stage is empty")
    `PCM_ASSERT_NEXT(a_stage2_advances, st2_valid_reg && rdy3, m_valid,
        "stage 2 beat did not reach the output")
    `PCM_ASSERT_NOW(a_abs_nonneg, m_valid && st3_abs_reg,
        !m_out_x[31] && !m_out_y[31] && !m_out_z[31],
        "absolute result is negative")
    `PCM_ASSERT_NEXT(a_accept_fills_st1, s_valid && s_ready, st1_valid_reg,
        "accepted beat not captured")

endmodule
